[hw/rtl/ps2mct_pkg.sv]
// Shared types, constants and helper functions for the PS/2 mouse cursor tracker.
package ps2mct_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd2;

    localparam logic [7:0] DEF_GRID_WIDTH  = 8'd80;
    localparam logic [7:0] DEF_GRID_HEIGHT = 8'd25;
    localparam logic [7:0] HOME_X          = 8'd40;
    localparam logic [7:0] HOME_Y          = 8'd12;

    // Bit 3 of the first packet byte is always set by the device.
    localparam int unsigned SYNC_BIT = 3;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_SECOND = 3'b010,
        PH_THIRD  = 3'b100
    } phase_t;

    typedef struct packed {
        logic       enable;
        logic [7:0] grid_width;
        logic [7:0] grid_height;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  cursor_x;
        logic [7:0]  cursor_y;
        logic        moved;
        logic [15:0] old_cell_index;
        logic [15:0] new_cell_index;
    } result_t;

    // Clamp a signed coordinate into 0 .. size-1; a size of zero acts as one.
    function automatic logic [7:0] clamp_coord(input logic signed [9:0] v,
                                               input logic [7:0] size);
        logic [7:0] top;
        top = (size == 8'd0) ? 8'd0 : size - 8'd1;
        if (v[9])
            return 8'd0;
        else if (v[8:0] > {1'b0, top})
            return top;
        else
            return v[7:0];
    endfunction

    function automatic logic [15:0] cell_index(input logic [7:0] x,
                                               input logic [7:0] y,
                                               input logic [7:0] width);
        logic [15:0] prod;
        prod = y * width;
        return prod + {8'd0, x};
    endfunction

endpackage

[hw/rtl/ps2mct_if.sv]
// Valid/ready channel interfaces for the input bytes and the cursor results.
interface ps2mct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       from_aux;

    modport source (output valid, output data_byte, output from_aux, input ready);
    modport sink   (input valid, input data_byte, input from_aux, output ready);
endinterface

interface ps2mct_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  cursor_x;
    logic [7:0]  cursor_y;
    logic        moved;
    logic [15:0] old_cell_index;
    logic [15:0] new_cell_index;

    modport source (output valid, output cursor_x, output cursor_y, output moved,
                    output old_cell_index, output new_cell_index, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y, input moved,
                    input old_cell_index, input new_cell_index, output ready);
endinterface

[hw/rtl/ps2mct_cfg_regs.sv]
// Configuration register file: enable and text grid size.
module ps2mct_cfg_regs
    import ps2mct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:      cfg_next.enable      = cfg_wdata[0];
                REG_GRID_WIDTH:  cfg_next.grid_width  = cfg_wdata;
                REG_GRID_HEIGHT: cfg_next.grid_height = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable      <= 1'b0;
            cfg_reg.grid_width  <= DEF_GRID_WIDTH;
            cfg_reg.grid_height <= DEF_GRID_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/ps2mct_core.sv]
// Packet assembly, cursor update, clamping and cell index computation.
module ps2mct_core
    import ps2mct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       from_aux,
    input  cfg_t       cfg,
    output logic       res_fire,
    output result_t    res
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] delta_x_reg;
    logic [7:0] delta_x_next;
    logic [7:0] pos_x_reg;
    logic [7:0] pos_x_next;
    logic [7:0] pos_y_reg;
    logic [7:0] pos_y_next;

    logic              live;
    logic signed [9:0] sum_x;
    logic signed [9:0] sum_y;
    logic [7:0]        new_x;
    logic [7:0]        new_y;

    assign live  = cfg.enable && from_aux;
    assign sum_x = signed'({2'b00, pos_x_reg}) + signed'({{2{delta_x_reg[7]}}, delta_x_reg});
    assign sum_y = signed'({2'b00, pos_y_reg}) - signed'({{2{data_byte[7]}}, data_byte});
    assign new_x = clamp_coord(sum_x, cfg.grid_width);
    assign new_y = clamp_coord(sum_y, cfg.grid_height);

    assign res.cursor_x       = new_x;
    assign res.cursor_y       = new_y;
    assign res.moved          = (new_x != pos_x_reg) || (new_y != pos_y_reg);
    assign res.old_cell_index = cell_index(pos_x_reg, pos_y_reg, cfg.grid_width);
    assign res.new_cell_index = cell_index(new_x, new_y, cfg.grid_width);

    always_comb
    begin
        phase_next   = phase_reg;
        delta_x_next = delta_x_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        res_fire     = 1'b0;
        if (live)
        begin
            case (phase_reg)
                PH_SECOND:
                begin
                    delta_x_next = data_byte;
                    phase_next   = PH_THIRD;
                end
                PH_THIRD:
                begin
                    pos_x_next = new_x;
                    pos_y_next = new_y;
                    phase_next = PH_FIRST;
                    res_fire   = 1'b1;
                end
                default:
                begin
                    // A first byte without the sync bit is dropped to regain alignment.
                    phase_next = data_byte[SYNC_BIT] ? PH_SECOND : PH_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FIRST;
            delta_x_reg <= 8'd0;
            pos_x_reg   <= HOME_X;
            pos_y_reg   <= HOME_Y;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            delta_x_reg <= delta_x_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
        end
    end

endmodule

[hw/rtl/ps2_mouse_cursor_tracker.sv]
// Top level of the PS/2 mouse cursor tracker: input register, core and result register.
// A packet's beat enters the result register when the core takes its third byte.
// Throughput: one byte per cycle; the input register and the result register each
// advance whenever the result register is empty or its beat is taken in the same cycle.
// Reset (asynchronous, active low) empties both registers, disables the block, sets the
// grid to 80 by 25, puts the cursor at column 40, row 12, and waits for a first byte.
module ps2_mouse_cursor_tracker
    import ps2mct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    ps2mct_in_if.sink              mouse,
    ps2mct_out_if.source           cursor,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t cfg;

    // Input register: holds one accepted byte until the core consumes it.
    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] in_data_reg;
    logic       in_aux_reg;

    // Result register: holds one finished beat until the sink takes it.
    logic    out_vld_reg;
    logic    out_vld_next;
    result_t out_res_reg;

    logic    advance;
    logic    step;
    logic    res_fire;
    result_t res;

    ps2mct_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ps2mct_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_data_reg),
        .from_aux  (in_aux_reg),
        .cfg       (cfg),
        .res_fire  (res_fire),
        .res       (res)
    );

    // The core may consume a byte whenever the result register can take its beat,
    // which also lets the input register refill in the same cycle.
    assign advance     = !out_vld_reg || cursor.ready;
    assign step        = in_vld_reg && advance;
    assign mouse.ready = !in_vld_reg || advance;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (mouse.ready)
        begin
            in_vld_next = mouse.valid;
        end
        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = step && res_fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers carry no reset; they are qualified by the valid bits.
    always_ff @(posedge clk)
    begin
        if (mouse.valid && mouse.ready)
        begin
            in_data_reg <= mouse.data_byte;
            in_aux_reg  <= mouse.from_aux;
        end
        if (step && res_fire)
        begin
            out_res_reg <= res;
        end
    end

    assign cursor.valid          = out_vld_reg;
    assign cursor.cursor_x       = out_res_reg.cursor_x;
    assign cursor.cursor_y       = out_res_reg.cursor_y;
    assign cursor.moved          = out_res_reg.moved;
    assign cursor.old_cell_index = out_res_reg.old_cell_index;
    assign cursor.new_cell_index = out_res_reg.new_cell_index;

endmodule

[tb/tb_ps2_mouse_cursor_tracker.sv]
// Self-checking testbench for the PS/2 mouse cursor tracker: directed table, random packets.
module tb_ps2_mouse_cursor_tracker
    import ps2mct_pkg::*;
;

    // Run shape. Enabled phases each feed about PHASE_BYTES used mouse bytes; with the
    // keyboard and stray bytes, the disabled phase and the directed table this gives
    // roughly 1100 bytes offered to the block.
    localparam int N_PHASES    = 9;
    localparam int PHASE_BYTES = 115;
    localparam int OFF_BYTES   = 40;
    // A taken byte waits in the input register and, closing a packet, in the result register,
    // so SETTLE quiet cycles are enough for a byte still in the pipe to finish.
    localparam int SETTLE      = 6;
    localparam int LONG_HOLD   = 80;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_PRINTS  = 30;

    // Position of the next byte within a three-byte movement packet.
    typedef enum logic [1:0]
    {
        AWAIT_HEAD = 2'd0,
        AWAIT_DX   = 2'd1,
        AWAIT_DY   = 2'd2
    } pkt_pos_e;

    // A directed row is a mouse byte whose result (if any) comes from the tracker
    // model, a mouse byte whose result is typed in, or a register write.
    typedef enum logic [1:0]
    {
        ROW_BYTE   = 2'd0,
        ROW_RESULT = 2'd1,
        ROW_REG    = 2'd2
    } row_kind_e;

    typedef struct packed
    {
        row_kind_e              kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [7:0]             value;
        logic                   aux;
        result_t                want;
    } row_t;

    localparam result_t NO_RESULT = '0;

    // Directed table. Reset leaves the block disabled with the cursor at 40,12 on an
    // 80 by 25 grid, so the first byte must vanish. After that: a head byte with the
    // sync bit clear, a byte from the keyboard side, a still packet, full-scale
    // deltas in both directions that pin the cursor to opposite corners, a head byte
    // with every flag bit set, a foreign byte in the middle of a packet, the largest
    // grid with the cursor driven to the far corner, and a zero-sized grid where the
    // clamp goes to 0 and the cell index collapses to the bare column.
    localparam row_t DIRECTED [30] = '{
        '{ROW_BYTE,   REG_ENABLE,      8'h08, 1'b1, NO_RESULT},
        '{ROW_REG,    REG_ENABLE,      8'h01, 1'b0, NO_RESULT},
        '{ROW_BYTE,   REG_ENABLE,      8'h00, 1'b1, NO_RESULT},
        '{ROW_BYTE,   REG_ENABLE,      8'h08, 1'b0, NO_RESULT},
        '{ROW_BYTE,   REG_ENABLE,      8'h08, 1'b1, NO_RESULT},
        '{ROW_BYTE,   REG_ENABLE,      8'h00, 1'b1, NO_RESULT},
        '{ROW_RESULT, REG_ENABLE,      8'h00, 1'b1,
          '{8'd40, 8'd12, 1'b0, 16'd1000, 16'd1000}},
        '{ROW_BYTE,   REG_ENABLE,      8'h08, 1'b1, NO_RESULT},
        '{ROW_BYTE,   REG_ENABLE,      8'h7F, 1'b1, NO_RESULT},
        '{ROW_RESULT, REG_ENABLE,      8'h80, 1'b1,
          '{8'd79, 8'd24, 1'b1, 16'd1000, 16'd1999}},
        '{ROW_BYTE,   REG_ENABLE,      8'hFF, 1'b1, NO_RESULT},
        '{ROW_BYTE,   REG_ENABLE,      8'h80, 1'b1, NO_RESULT},
        '{ROW_RESULT, REG_ENABLE,      8'h7F, 1'b1,
          '{8'd0, 8'd0, 1'b1, 16'd1999, 16'd0}},
        '{ROW_BYTE,   REG_ENABLE,      8'h08, 1'b1, NO_RESULT},
        '{ROW_BYTE,   REG_ENABLE,      8'h05, 1'b1, NO_RESULT},
        '{ROW_BYTE,   REG_ENABLE,      8'hAA, 1'b0, NO_RESULT},
        '{ROW_RESULT, REG_ENABLE,      8'hFE, 1'b1,
          '{8'd5, 8'd2, 1'b1, 16'd0, 16'd165}},
        '{ROW_REG,    REG_GRID_WIDTH,  8'hFF, 1'b0, NO_RESULT},
        '{ROW_REG,    REG_GRID_HEIGHT, 8'hFF, 1'b0, NO_RESULT},
        '{ROW_BYTE,   REG_ENABLE,      8'h08, 1'b1, NO_RESULT},
        '{ROW_BYTE,   REG_ENABLE,      8'h7F, 1'b1, NO_RESULT},
        '{ROW_RESULT, REG_ENABLE,      8'h81, 1'b1,
          '{8'd132, 8'd129, 1'b1, 16'd515, 16'd33027}},
        '{ROW_BYTE,   REG_ENABLE,      8'h08, 1'b1, NO_RESULT},
        '{ROW_BYTE,   REG_ENABLE,      8'h7F, 1'b1, NO_RESULT},
        '{ROW_RESULT, REG_ENABLE,      8'h80, 1'b1,
          '{8'd254, 8'd254, 1'b1, 16'd33027, 16'd65024}},
        '{ROW_REG,    REG_GRID_WIDTH,  8'h00, 1'b0, NO_RESULT},
        '{ROW_REG,    REG_GRID_HEIGHT, 8'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE,   REG_ENABLE,      8'h08, 1'b1, NO_RESULT},
        '{ROW_BYTE,   REG_ENABLE,      8'h01, 1'b1, NO_RESULT},
        '{ROW_RESULT, REG_ENABLE,      8'h01, 1'b1,
          '{8'd0, 8'd0, 1'b1, 16'd254, 16'd0}}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    ps2mct_in_if  mouse_ch ();
    ps2mct_out_if cursor_ch ();

    ps2_mouse_cursor_tracker i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mouse     (mouse_ch),
        .cursor    (cursor_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Tracker model state: its own copy of the registers and of the cursor.
    logic       trk_en;
    logic [7:0] trk_w;
    logic [7:0] trk_h;
    pkt_pos_e   trk_pos;
    logic [7:0] trk_dx;
    logic [7:0] trk_x;
    logic [7:0] trk_y;

    // Cursor results still owed by the block, oldest first.
    result_t cursor_due [$];

    int errors          = 0;
    int bytes_offered   = 0;
    int mouse_bytes_used = 0;
    int results_seen    = 0;
    int regs_written    = 0;
    int quiet_cycles    = 0;

    // Knobs shared between the stimulus thread and the result sink.
    int idle_pct    = 0;
    bit calm        = 1'b0;
    int long_asks   = 0;
    int long_done   = 0;
    int stall_left  = 0;

    result_t oldest_cursor;
    result_t seen_cursor;

    // Clamp into 0 .. size-1; a zero size behaves like a one-cell grid.
    function automatic int fit_to_grid(input int v, input logic [7:0] size);
        int top;
        top = (size == 8'd0) ? 0 : int'(size) - 1;
        if (v < 0)
            return 0;
        if (v > top)
            return top;
        return v;
    endfunction

    // Row-major cell number on the grid as currently configured, kept to 16 bits.
    function automatic logic [15:0] cell_of(input logic [7:0] x, input logic [7:0] y);
        return 16'(int'(y) * int'(trk_w) + int'(x));
    endfunction

    // Feed one accepted byte to the tracker model. Returns 1 when the byte closes a
    // packet, with the cursor beat the block has to produce for it in r.
    function automatic bit track_byte(input logic [7:0] d, input logic a, output result_t r);
        int nx;
        int ny;
        r = '0;
        if (!trk_en || !a)
            return 1'b0;
        case (trk_pos)
            AWAIT_DX:
            begin
                trk_dx  = d;
                trk_pos = AWAIT_DY;
                return 1'b0;
            end
            AWAIT_DY:
            begin
                // X follows the delta, Y runs the other way: screen rows grow downward.
                nx = fit_to_grid(int'(trk_x) + int'($signed(trk_dx)), trk_w);
                ny = fit_to_grid(int'(trk_y) - int'($signed(d)), trk_h);
                r.cursor_x       = 8'(nx);
                r.cursor_y       = 8'(ny);
                r.moved          = (8'(nx) != trk_x) || (8'(ny) != trk_y);
                r.old_cell_index = cell_of(trk_x, trk_y);
                r.new_cell_index = cell_of(8'(nx), 8'(ny));
                trk_x   = 8'(nx);
                trk_y   = 8'(ny);
                trk_pos = AWAIT_HEAD;
                return 1'b1;
            end
            default:
            begin
                // A head byte without the sync bit is dropped so the stream can realign.
                trk_pos = d[SYNC_BIT] ? AWAIT_DX : AWAIT_HEAD;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("[%0t] cursor beat %0d: %s is %0d, expected %0d",
                     $time, results_seen, what, got, want);
    endtask

    task automatic check_cursor(input result_t got, input result_t want);
        if (got.cursor_x !== want.cursor_x)
            report_mismatch("cursor_x", got.cursor_x, want.cursor_x);
        if (got.cursor_y !== want.cursor_y)
            report_mismatch("cursor_y", got.cursor_y, want.cursor_y);
        if (got.moved !== want.moved)
            report_mismatch("moved", got.moved, want.moved);
        if (got.old_cell_index !== want.old_cell_index)
            report_mismatch("old_cell_index", got.old_cell_index, want.old_cell_index);
        if (got.new_cell_index !== want.new_cell_index)
            report_mismatch("new_cell_index", got.new_cell_index, want.new_cell_index);
    endtask

    // Offer one byte, possibly after a random gap, and hold it until the block takes
    // it. Valid stays high afterwards so back-to-back bytes need no extra assignment.
    // A typed result, when given, stands in for the model's.
    task automatic push_byte(input logic [7:0] d, input logic a,
                             input bit typed, input result_t typed_r);
        result_t r;
        bit      has;
        if (!calm && ($urandom_range(0, 99) < idle_pct))
        begin
            mouse_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        mouse_ch.valid     <= 1'b1;
        mouse_ch.data_byte <= d;
        mouse_ch.from_aux  <= a;
        @(posedge clk);
        while (!mouse_ch.ready)
            @(posedge clk);
        bytes_offered++;
        if (trk_en && a)
            mouse_bytes_used++;
        has = track_byte(d, a, r);
        if (typed)
            cursor_due.push_back(typed_r);
        else if (has)
            cursor_due.push_back(r);
    endtask

    // A packet byte, now and then preceded by a keyboard byte that must be skipped.
    task automatic push_mouse_byte(input logic [7:0] d);
        if ($urandom_range(0, 9) == 0)
            push_byte(8'($urandom), 1'b0, 1'b0, NO_RESULT);
        push_byte(d, 1'b1, 1'b0, NO_RESULT);
    endtask

    // Half the deltas are small so the cursor wanders inside the grid; the rest span
    // the full signed range and hit the clamps.
    function automatic logic [7:0] pick_delta();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 16) - 8);
        return 8'($urandom);
    endfunction

    // Stop offering and wait for every owed cursor beat.
    task automatic wait_for_results();
        mouse_ch.valid <= 1'b0;
        @(posedge clk);
        while (cursor_due.size() != 0)
            @(posedge clk);
    endtask

    // Make the block idle before a register write: bytes that close no packet may
    // still sit in the pipe after the last beat, so give them time to drain too.
    task automatic drain();
        wait_for_results();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        case (idx)
            REG_ENABLE:      trk_en = v[0];
            REG_GRID_WIDTH:  trk_w  = v;
            REG_GRID_HEIGHT: trk_h  = v;
            default:         ;
        endcase
        regs_written++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Result sink: checks each beat against the oldest owed result and drives ready.
    // Ready drops in random bursts, and once for a long hold asked by the stimulus so
    // that both pipeline registers fill and the input side backs up.
    always @(posedge clk)
    begin
        if (rst_n && cursor_ch.valid && cursor_ch.ready)
        begin
            seen_cursor.cursor_x       = cursor_ch.cursor_x;
            seen_cursor.cursor_y       = cursor_ch.cursor_y;
            seen_cursor.moved          = cursor_ch.moved;
            seen_cursor.old_cell_index = cursor_ch.old_cell_index;
            seen_cursor.new_cell_index = cursor_ch.new_cell_index;
            results_seen++;
            if (cursor_due.size() == 0)
            begin
                report_mismatch("unexpected beat, cursor_x", seen_cursor.cursor_x, 0);
            end
            else
            begin
                oldest_cursor = cursor_due.pop_front();
                check_cursor(seen_cursor, oldest_cursor);
            end
        end

        if (stall_left > 0)
        begin
            cursor_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (long_asks != long_done)
        begin
            long_done++;
            cursor_ch.ready <= 1'b0;
            stall_left = LONG_HOLD - 1;
        end
        else if (!calm && ($urandom_range(0, 99) < idle_pct))
        begin
            cursor_ch.ready <= 1'b0;
            stall_left = $urandom_range(1, 7) - 1;
        end
        else
        begin
            cursor_ch.ready <= 1'b1;
        end
    end

    // Watchdog: any beat on either side counts as progress.
    always @(posedge clk)
    begin
        if ((mouse_ch.valid && mouse_ch.ready) || (cursor_ch.valid && cursor_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[%0t] no beat for %0d cycles, %0d cursor beats still owed",
                     $time, QUIET_LIMIT, cursor_due.size());
            $display("ps2_mouse_cursor_tracker verification failed");
            $finish;
        end
    end

    initial
    begin
        int         ph;
        int         start_used;
        int         start_offered;
        int         pick;
        bit         en;
        bit         paused;
        logic [7:0] w;
        logic [7:0] h;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_ENABLE;
        cfg_wdata          = '0;
        mouse_ch.valid     = 1'b0;
        mouse_ch.data_byte = '0;
        mouse_ch.from_aux  = 1'b0;

        trk_en  = 1'b0;
        trk_w   = DEF_GRID_WIDTH;
        trk_h   = DEF_GRID_HEIGHT;
        trk_pos = AWAIT_HEAD;
        trk_dx  = '0;
        trk_x   = HOME_X;
        trk_y   = HOME_Y;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with light random gaps on both sides.
        idle_pct = 15;
        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_REG)
            begin
                drain();
                write_reg(DIRECTED[i].idx, DIRECTED[i].value);
            end
            else
            begin
                push_byte(DIRECTED[i].value, DIRECTED[i].aux,
                          DIRECTED[i].kind == ROW_RESULT, DIRECTED[i].want);
            end
        end

        // Random phases. Each one picks a grid, mostly well-formed packets with random
        // content follow, and a share of stray bytes and cut-short packets knocks the
        // framing loose so that resync gets exercised. Phase 3 runs disabled, phase 7
        // shrinks the grid under a cursor that may sit outside it, and the last phase
        // runs without any gaps.
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            en = 1'b1;
            w  = 8'($urandom_range(1, 255));
            h  = 8'($urandom_range(1, 255));
            idle_pct = 20;
            case (ph)
                0:
                begin
                    w = DEF_GRID_WIDTH;
                    h = DEF_GRID_HEIGHT;
                end
                1:
                begin
                    w = 8'd1;
                    h = 8'd1;
                    idle_pct = 35;
                end
                2:
                begin
                    w = 8'd255;
                    h = 8'd255;
                    idle_pct = 10;
                end
                3:  en = 1'b0;
                4:
                begin
                    w = 8'd255;
                    h = 8'd1;
                end
                5:
                begin
                    w = 8'd1;
                    h = 8'd255;
                    idle_pct = 0;
                end
                7:
                begin
                    w = 8'($urandom_range(1, 16));
                    h = 8'($urandom_range(1, 16));
                end
                default: ;
            endcase

            drain();
            write_reg(REG_ENABLE, {7'd0, en});
            write_reg(REG_GRID_WIDTH, w);
            write_reg(REG_GRID_HEIGHT, h);
            calm = (ph == N_PHASES - 1);
            if (ph == 2)
                long_asks++;

            start_used    = mouse_bytes_used;
            start_offered = bytes_offered;
            paused        = 1'b0;
            while (en ? (mouse_bytes_used - start_used < PHASE_BYTES)
                      : (bytes_offered - start_offered < OFF_BYTES))
            begin
                // Halfway through phase 4 the sender stops until every owed cursor beat is back.
                if (ph == 4 && !paused && (mouse_bytes_used - start_used >= PHASE_BYTES / 2))
                begin
                    wait_for_results();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    push_mouse_byte(8'($urandom) | 8'h08);
                    push_mouse_byte(pick_delta());
                    push_mouse_byte(pick_delta());
                end
                else if (pick < 90)
                begin
                    push_byte(8'($urandom), 1'($urandom), 1'b0, NO_RESULT);
                end
                else
                begin
                    push_mouse_byte(8'($urandom) | 8'h08);
                    push_mouse_byte(pick_delta());
                end
            end
        end

        drain();

        $display("Covered %0d bytes (%0d of them moved the tracker), %0d cursor beats checked,",
                 bytes_offered, mouse_bytes_used, results_seen);
        $display("%0d register writes over grids from 0x0 to 255x255, with long stalls and drains.",
                 regs_written);
        if (errors == 0)
            $display("ps2_mouse_cursor_tracker verification clean");
        else
            $display("ps2_mouse_cursor_tracker verification failed");
        $finish;
    end

endmodule
